@@ rtl/core/pbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_pkg: shared types and constants of the period and bpm meter
// widths of the counter, the divider and the fixed point result, plus the
// state encodings and the result saturation helper
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int COUNT_W   = 24;
  localparam int FRAC_W    = 16;
  localparam int RATE_W    = 27;
  localparam int VALUE_W   = 48;
  localparam int DVD_W     = 64;
  localparam int DVS_W     = 32;
  localparam int STEP_W    = $clog2(DVD_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DVS_W-1:0]   MCOUNT_MAX = {DVS_W{1'b1}};
  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(2041666);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 1'b1;

  typedef enum logic [1:0] {
    MODE_BPM     = 2'd0,
    MODE_AVG_BPM = 2'd1,
    MODE_PERIOD  = 2'd2,
    MODE_FREQ    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_WAIT_LOW   = 2'd0,
    PH_WAIT_HIGH  = 2'd1,
    PH_COUNT_HIGH = 2'd2,
    PH_COUNT_LOW  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_ACC,
    ST_START2,
    ST_DIV2,
    ST_DONE
  } seq_state_t;

  // one finished period, valid for the transaction that closes it
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } meas_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [VALUE_W-1:0] sat_value(input logic [DVD_W-1:0] q);
    logic [VALUE_W-1:0] r;
    r = (|q[DVD_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : q[VALUE_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/period_and_bpm_meter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// period_and_bpm_meter_top: reciprocal period counter with bpm readout
// edge tracker, bit-serial divider and result sequencer
// ----------------------------------------------------------------------------
// Each input transaction is one counting tick carrying the sampled signal
// level; a tick is taken every cycle while no result is being worked out.
// After a low level the first rising edge starts a count, the next rising
// edge closes it and one result follows; the period right after is skipped.
// The tick that closes a period holds the input while the result is worked
// out: in modes 0, 2 and 3 the divider runs once and its quotient goes to the
// output register; mode 1 (average bpm) runs the divider twice, with an
// accumulate state and a restart state between the runs. A stalled result
// side adds its stall. All runs use the single 64-step bit-serial divider.
// shown_value is unsigned fixed point with 16 fraction bits and saturates.
// Configuration is to be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module period_and_bpm_meter_top
  import pbm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_signal_level,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COUNT_W-1:0]        out_period_ticks,
  output logic [VALUE_W-1:0]        out_shown_value,
  output logic [1:0]                out_value_kind,
  output logic                      out_count_overflowed,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_wdata
);

  logic [RATE_W-1:0]  rate_r;
  mode_t              mode_r;
  seq_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0] t_r;
  logic               ovf_r;
  logic [DVD_W-1:0]   sum_r;
  logic [DVS_W-1:0]   mcount_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_period_ticks_r;
  logic [VALUE_W-1:0] out_shown_value_r;
  logic [1:0]         out_value_kind_r;
  logic               out_ovf_r;

  logic               in_fire;
  meas_t              meas;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_q;
  div_status_t        div_st;
  logic [RATE_W-1:0]  rate_eff;
  logic [RATE_W+5:0]  rate_x60;
  logic [DVD_W:0]     sum_add;
  logic               load_out;
  logic               acc_en;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  pbm_edge_fsm u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (in_fire),
    .level (in_signal_level),
    .meas  (meas)
  );

  pbm_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .status   (div_st)
  );

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      mode_r <= MODE_BPM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_RATE:    rate_r <= cfg_wdata;
        REG_DISPLAY_MODE: mode_r <= mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
  // 60 * rate as 64 * rate - 4 * rate
  assign rate_x60 = ({6'b0, rate_eff} << 6) - ({6'b0, rate_eff} << 2);

  // first division operands from the period just closed, second from the running average
  always_comb begin
    div_dvd = DVD_W'(rate_x60) << FRAC_W;
    div_dvs = DVS_W'(meas.count);
    case (mode_r)
      MODE_PERIOD: begin
        div_dvd = DVD_W'(meas.count) << FRAC_W;
        div_dvs = DVS_W'(rate_eff);
      end
      MODE_FREQ: begin
        div_dvd = DVD_W'(rate_eff) << FRAC_W;
      end
      default: ;
    endcase
    if (state_r == ST_START2) begin
      div_dvd = sum_r;
      div_dvs = mcount_r;
    end
  end

  assign div_start = (in_fire && meas.done) || (state_r == ST_START2);
  assign sum_add   = {1'b0, sum_r} + (DVD_W + 1)'(sat_value(div_q));
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign acc_en    = (state_r == ST_ACC) && (mcount_r != MCOUNT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && meas.done) state_nxt = ST_DIV1;
      ST_DIV1: begin
        if (div_st.done) state_nxt = (mode_r == MODE_AVG_BPM) ? ST_ACC : ST_DONE;
      end
      ST_ACC:    state_nxt = ST_START2;
      ST_START2: state_nxt = ST_DIV2;
      ST_DIV2:   if (div_st.done) state_nxt = ST_DONE;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && meas.done) begin
      t_r   <= meas.count;
      ovf_r <= meas.ovf;
    end
  end

  // running average state, saturating sum and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      mcount_r <= '0;
    end else if (acc_en) begin
      sum_r    <= sum_add[DVD_W] ? {DVD_W{1'b1}} : sum_add[DVD_W-1:0];
      mcount_r <= mcount_r + DVS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_period_ticks_r <= t_r;
      out_shown_value_r  <= sat_value(div_q);
      out_value_kind_r   <= mode_r;
      out_ovf_r          <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_period_ticks     = out_period_ticks_r;
  assign out_shown_value      = out_shown_value_r;
  assign out_value_kind       = out_value_kind_r;
  assign out_count_overflowed = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_div_only_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider busy outside a division state");

  a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && meas.done |=> state_r == ST_DIV1 && div_st.busy)
    else $error("closed period did not start the divider");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && state_r == ST_IDLE)
    else $error("result load did not present a transaction");

  a_mcount_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |=> mcount_r >= $past(mcount_r) && mcount_r != '0)
    else $error("average count went backwards or stayed zero");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pbm_edge_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_edge_fsm: edge tracker and period counter
// waits for low then high, counts ticks to the next rising edge with
// saturation, then rearms
// ----------------------------------------------------------------------------
module pbm_edge_fsm
  import pbm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  tick,
  input  wire logic  level,
  output meas_t      meas
);

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               sat_r, sat_nxt;

  logic               at_max;
  logic [COUNT_W-1:0] count_bump;
  logic               sat_bump;

  assign at_max     = (count_r == COUNT_MAX);
  assign count_bump = at_max ? count_r : count_r + COUNT_W'(1);
  assign sat_bump   = sat_r | at_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_LOW;
      count_r <= '0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    sat_nxt    = sat_r;
    meas.done  = 1'b0;
    meas.count = count_bump;
    meas.ovf   = sat_bump;
    if (tick) begin
      unique case (phase_r)
        PH_WAIT_LOW: begin
          if (!level) phase_nxt = PH_WAIT_HIGH;
        end
        PH_WAIT_HIGH: begin
          if (level) begin
            count_nxt = '0;
            sat_nxt   = 1'b0;
            phase_nxt = PH_COUNT_HIGH;
          end
        end
        PH_COUNT_HIGH: begin
          count_nxt = count_bump;
          sat_nxt   = sat_bump;
          if (!level) phase_nxt = PH_COUNT_LOW;
        end
        PH_COUNT_LOW: begin
          count_nxt = count_bump;
          sat_nxt   = sat_bump;
          if (level) begin
            meas.done = 1'b1;
            phase_nxt = PH_WAIT_LOW;
          end
        end
        default: phase_nxt = PH_WAIT_LOW;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pbm_serial_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbm_serial_div: bit-serial restoring divider
// one quotient bit per cycle, dividend shifted out msb first while the
// quotient shifts in; a zero divisor gives an all-ones quotient
// ----------------------------------------------------------------------------
module pbm_serial_div
  import pbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DVS_W-1:0]  divisor,
  output logic [DVD_W-1:0]       quotient,
  output div_status_t            status
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              q_bit;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvs_r};
  assign q_bit   = ~diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == {STEP_W{1'b1}}) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient    = dvd_r;
  assign status.busy = busy_r;
  assign status.done = busy_r && (step_r == {STEP_W{1'b1}});

endmodule
`default_nettype wire

@@ tb/period_and_bpm_meter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_and_bpm_meter_top_tb: self-checking bench for the period and bpm meter
// Feeds level ticks as rising-edge periods, with noise and random gaps on
// both channels, under several rate and display settings. A local model of
// the edge tracker and the fixed point arithmetic predicts every reading,
// and each reading that comes out is checked field by field.
// ----------------------------------------------------------------------------
module period_and_bpm_meter_top_tb;
  import pbm_pkg::*;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 160;
  localparam int PHASES        = 8;
  localparam int PHASE_TICKS   = 220;
  localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0] ticks;
    logic [VALUE_W-1:0] value;
    mode_t              kind;
    logic               ovf;
  } reading_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    mode_t             mode;
    int                pre_hi;
    int                pre_lo;
    int                hi_n;
    int                lo_n;
    bit                typed;
    reading_t          want;
  } drill_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_signal_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COUNT_W-1:0]   out_period_ticks;
  logic [VALUE_W-1:0]   out_shown_value;
  logic [1:0]           out_value_kind;
  logic                 out_count_overflowed;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TICK_RATE;
  logic [RATE_W-1:0]    cfg_wdata = '0;

  // model state and shadow of the configuration
  phase_t             meter_phase = PH_WAIT_LOW;
  logic [COUNT_W-1:0] meter_cnt = '0;
  logic               meter_sat = 1'b0;
  logic [63:0]        bpm_total = '0;
  logic [31:0]        bpm_samples = '0;
  logic [RATE_W-1:0]  rate_reg = RATE_RESET;
  mode_t              mode_reg = MODE_BPM;

  reading_t pending_readings[$];
  drill_t   drills[$];
  int       fault_count = 0;
  int       cycle_count = 0;
  int       used_ticks = 0;
  int       tx_gap = 1;
  bit       tx_quiet = 1'b0;
  bit       rx_quiet = 1'b0;

  period_and_bpm_meter_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_signal_level      (in_signal_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_period_ticks     (out_period_ticks),
    .out_shown_value      (out_shown_value),
    .out_value_kind       (out_value_kind),
    .out_count_overflowed (out_count_overflowed),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [VALUE_W-1:0] clip_value(input logic [63:0] q);
    return (q > 64'(VALUE_TOP)) ? VALUE_TOP : q[VALUE_W-1:0];
  endfunction

  function automatic logic [63:0] effective_rate();
    return (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
  endfunction

  function automatic logic [VALUE_W-1:0] bpm_fixed(input logic [63:0] t);
    if (t == 0) return VALUE_TOP;
    return clip_value(((64'd60 * effective_rate()) << FRAC_W) / t);
  endfunction

  function automatic void bump_tick_count();
    if (meter_cnt == COUNT_MAX) meter_sat = 1'b1;
    else meter_cnt = meter_cnt + 1'b1;
  endfunction

  // one tick through the edge tracker; returns 1 when a period closes
  function automatic bit predict_reading(input logic lvl, output reading_t r,
                                         output bit moved);
    logic [63:0] t;
    logic [63:0] b;
    bit          got;
    got = 1'b0;
    moved = 1'b1;
    r = '0;
    case (meter_phase)
      PH_WAIT_LOW: begin
        if (!lvl) meter_phase = PH_WAIT_HIGH;
        else moved = 1'b0;
      end
      PH_WAIT_HIGH: begin
        if (lvl) begin
          meter_cnt = '0;
          meter_sat = 1'b0;
          meter_phase = PH_COUNT_HIGH;
        end else begin
          moved = 1'b0;
        end
      end
      PH_COUNT_HIGH: begin
        bump_tick_count();
        if (!lvl) meter_phase = PH_COUNT_LOW;
      end
      default: begin
        bump_tick_count();
        if (lvl) begin
          t = 64'(meter_cnt);
          r.ticks = meter_cnt;
          r.kind = mode_reg;
          r.ovf = meter_sat;
          case (mode_reg)
            MODE_AVG_BPM: begin
              b = 64'(bpm_fixed(t));
              if (bpm_samples != MCOUNT_MAX) begin
                bpm_total = (bpm_total > ~64'd0 - b) ? ~64'd0 : bpm_total + b;
                bpm_samples = bpm_samples + 1'b1;
              end
              r.value = clip_value(bpm_total / 64'(bpm_samples));
            end
            MODE_PERIOD: r.value = clip_value((t << FRAC_W) / effective_rate());
            MODE_FREQ: r.value = (t == 0) ? VALUE_TOP :
                                 clip_value((effective_rate() << FRAC_W) / t);
            default: r.value = bpm_fixed(t);
          endcase
          got = 1'b1;
          meter_phase = PH_WAIT_LOW;
        end
      end
    endcase
    return got;
  endfunction

  task automatic flag_fault(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fault_count++;
  endtask

  // valid stays up into the next tick when no gap is drawn
  task automatic send_tick(input logic lvl);
    reading_t r;
    bit       moved;
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_signal_level <= lvl;
    do @(posedge clk); while (!in_ready);
    if (predict_reading(lvl, r, moved)) pending_readings.push_back(r);
    if (moved) used_ticks++;
    tx_gap = draw_gap(tx_quiet);
    if (tx_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_period(input int pre_hi, input int pre_lo, input int hi_n,
                             input int lo_n);
    repeat (pre_hi) send_tick(1'b1);
    repeat (pre_lo) send_tick(1'b0);
    send_tick(1'b1);
    repeat (hi_n) send_tick(1'b1);
    repeat (lo_n) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // waits until every predicted reading has come out, then lets the bench settle
  task automatic wait_idle();
    if (tx_gap == 0) begin
      in_valid <= 1'b0;
      tx_gap = 1;
    end
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [RATE_W-1:0] rate, input mode_t mode);
    logic [RATE_W-1:0] junk;
    junk = RATE_W'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_TICK_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= REG_DISPLAY_MODE;
    cfg_wdata <= {junk[RATE_W-1:2], mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_reg = rate;
    mode_reg = mode;
  endtask

  function automatic drill_t mk_drill(input logic [RATE_W-1:0] rate, input mode_t mode,
                                      input int pre_hi, input int pre_lo,
                                      input int hi_n, input int lo_n,
                                      input bit typed, input reading_t want);
    drill_t d;
    d.rate = rate;
    d.mode = mode;
    d.pre_hi = pre_hi;
    d.pre_lo = pre_lo;
    d.hi_n = hi_n;
    d.lo_n = lo_n;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  task automatic check_reading();
    reading_t w;
    if (pending_readings.size() == 0) begin
      flag_fault($sformatf("reading with none due, ticks %0d", out_period_ticks));
      return;
    end
    w = pending_readings.pop_front();
    if (out_period_ticks !== w.ticks)
      flag_fault($sformatf("period_ticks %0d, due %0d", out_period_ticks, w.ticks));
    if (out_shown_value !== w.value)
      flag_fault($sformatf("shown_value %0d, due %0d", out_shown_value, w.value));
    if (out_value_kind !== w.kind)
      flag_fault($sformatf("value_kind %0d, due %0d", out_value_kind, w.kind));
    if (out_count_overflowed !== w.ovf)
      flag_fault($sformatf("count_overflowed %0b, due %0b", out_count_overflowed, w.ovf));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && out_ready) check_reading();
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(rx_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    drill_t            row;
    reading_t          want;
    logic [RATE_W-1:0] rate;
    int                sel;
    int                goal;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, expectations typed in where they are obvious
    want = '0;
    drills.push_back(mk_drill(RATE_RESET, MODE_BPM, 1, 2, 0, 1, 1'b0, want));
    want = '{ticks: 24'd2, value: 48'h2_0000, kind: MODE_PERIOD, ovf: 1'b0};
    drills.push_back(mk_drill(RATE_W'(1), MODE_PERIOD, 0, 1, 0, 1, 1'b1, want));
    // rate zero behaves as one tick per second
    want = '{ticks: 24'd2, value: 48'h8000, kind: MODE_FREQ, ovf: 1'b0};
    drills.push_back(mk_drill('0, MODE_FREQ, 0, 1, 0, 1, 1'b1, want));
    want = '0;
    drills.push_back(mk_drill(RATE_MAX, MODE_BPM, 0, 1, 1, 1, 1'b0, want));
    drills.push_back(mk_drill(RATE_MAX, MODE_AVG_BPM, 0, 1, 0, 1, 1'b0, want));
    drills.push_back(mk_drill(RATE_MAX, MODE_AVG_BPM, 0, 1, 1, 2, 1'b0, want));

    foreach (drills[i]) begin
      row = drills[i];
      if (row.rate != rate_reg || row.mode != mode_reg) begin
        wait_idle();
        load_settings(row.rate, row.mode);
      end
      tx_quiet = 1'($urandom_range(0, 1));
      rx_quiet = 1'($urandom_range(0, 1));
      send_period(row.pre_hi, row.pre_lo, row.hi_n, row.lo_n);
      if (row.typed) pending_readings[pending_readings.size() - 1] = row.want;
    end

    // random phases, one setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: rate = RATE_W'(1);
        1: rate = RATE_MAX;
        2: rate = '0;
        3: rate = RATE_RESET;
        default: rate = RATE_W'($urandom_range(0, 32'(RATE_MAX)));
      endcase
      wait_idle();
      load_settings(rate, mode_t'(p % 4));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      goal = used_ticks + PHASE_TICKS;
      while (used_ticks < goal) begin
        if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
        if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          // noise and broken periods
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          send_period(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                      $urandom_range(1, 3), $urandom_range(0, 10),
                      (sel > 96) ? $urandom_range(100, 400) : $urandom_range(1, 10));
        end
      end
    end

    wait_idle();
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
